>>> src/two_level_perfect_hash_insert_macros.svh
// Assertion macros used by the checker file of the hash table block.
`ifndef TWO_LEVEL_PERFECT_HASH_INSERT_MACROS_SVH
`define TWO_LEVEL_PERFECT_HASH_INSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is asserted.
`define TLPH_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define TLPH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> src/tlph_pkg.sv
package tlph_pkg;

    localparam int MAX_BUCKETS_DEF = 16;
    localparam int MAX_SLOTS_DEF   = 32;

    localparam int KEY_W    = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Dividend of the remainder unit: a 32-bit product plus a 16-bit addend.
    localparam int DVD_W       = 33;
    localparam int DVS_W       = 16;
    localparam int CNT_W       = 6;
    localparam int LONG_STEPS  = 33;
    localparam int SHORT_STEPS = 16;

    localparam logic [15:0] OUTER_MUL_RST    = 16'd3;
    localparam logic [15:0] OUTER_ADD_RST    = 16'd42;
    localparam logic [15:0] PRIME_RST        = 16'd101;
    localparam logic [4:0]  BUCKET_COUNT_RST = 5'd9;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_INSERT = 2'd1,
        FN_READ   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_OUTER_MUL    = 2'd0,
        CFG_OUTER_ADD    = 2'd1,
        CFG_PRIME        = 2'd2,
        CFG_BUCKET_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic             short_op;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> src/two_level_perfect_hash_insert.sv
// Two-level perfect hash table with a slot store.
// Commands: pulse start while busy is low to hand over one word on the i_ ports.
// i_func selects load (write one bucket's size, multiplier and addend), insert
// (hash i_key to a bucket and a slot and store it) or read (return one slot).
// Each command gives exactly one result word, shown for a single cycle with
// o_done high; the receiver cannot hold it off and must take it then.
// Load answers from the dispatch state, read from a RAM wait state after it;
// insert time is set by the shared remainder unit, which runs a modulo by the
// prime over the whole dividend and one by the bucket count or bucket size
// over its low 16 bits, four uses for an insert that reaches its slot. One
// command runs at a time; busy stays high until its result word is produced.
// Configuration sits on an APB port (outer multiplier, outer addend, prime,
// bucket count at byte addresses 0, 4, 8, 12); write it only while idle.
// Reset sets the registers to their defaults, clears the bucket tables, and
// then sweeps the slot store to zero, one entry a cycle; busy stays high until
// the sweep has reached the last entry. APB keeps working.
module two_level_perfect_hash_insert
    import tlph_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_key,
    input  logic [3:0]         i_bucket_index,
    input  logic [4:0]         i_slot_index,
    input  logic [5:0]         i_bucket_size,
    input  logic [15:0]        i_bucket_mul,
    input  logic [15:0]        i_bucket_add,
    // Result channel.
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [3:0]         o_hit_bucket,
    output logic [4:0]         o_hit_slot,
    output logic [15:0]        o_read_value,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DEPTH = MAX_BUCKETS * MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_MUL,
        S_DIVA,
        S_WAITA,
        S_DIVB,
        S_WAITB,
        S_BKT,
        S_WRITE,
        S_RDWAIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [15:0] r_outer_mul;
    logic [15:0] r_outer_add;
    logic [15:0] r_prime;
    logic [4:0]  r_bucket_count;

    // Per-bucket parameters, read at the single address r_bsel.
    logic [5:0]  r_bkt_size [MAX_BUCKETS];
    logic [15:0] r_bkt_mul  [MAX_BUCKETS];
    logic [15:0] r_bkt_add  [MAX_BUCKETS];

    // Latched command word and working registers.
    t_func          r_func;
    logic [15:0]    r_key;
    logic [3:0]     r_bidx;
    logic [5:0]     r_sidx;
    logic [5:0]     r_in_size;
    logic [15:0]    r_in_mul;
    logic [15:0]    r_in_add;
    logic [BW-1:0]  r_bsel;
    logic           r_phase;
    logic [15:0]    r_mul_a;
    logic [15:0]    r_add;
    logic [31:0]    r_prod;
    logic [15:0]    r_h;
    logic [5:0]     r_size;
    logic [AW-1:0]  r_clr;

    // Result word.
    logic        r_done;
    t_status     r_status;
    logic [3:0]  r_hbkt;
    logic [4:0]  r_hslot;
    logic [15:0] r_val;

    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             accept;
    logic             cfg_wr;
    t_cfg_idx         cfg_idx;
    logic             load_bad;
    logic             regs_bad;
    logic             read_bad;
    logic [AW-1:0]    slot_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic             ram_re;
    logic [KEY_W-1:0] ram_rdata;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            CFG_OUTER_MUL:    prdata = PDATA_W'(r_outer_mul);
            CFG_OUTER_ADD:    prdata = PDATA_W'(r_outer_add);
            CFG_PRIME:        prdata = PDATA_W'(r_prime);
            CFG_BUCKET_COUNT: prdata = PDATA_W'(r_bucket_count);
            default:          prdata = '0;
        endcase
    end

    // Range checks for each command.
    assign load_bad = (32'(r_bidx) >= MAX_BUCKETS) || (32'(r_in_size) > MAX_SLOTS);
    assign regs_bad = (r_bucket_count == 5'd0) || (32'(r_bucket_count) > MAX_BUCKETS)
                      || (r_prime == 16'd0);
    assign read_bad = (32'(r_bidx) >= MAX_BUCKETS) || (r_sidx >= r_bkt_size[r_bsel])
                      || (32'(r_sidx) >= MAX_SLOTS);

    // Buckets are laid out one after another, MAX_SLOTS entries each.
    assign slot_addr = AW'(r_bsel) * AW'(MAX_SLOTS) + AW'(r_sidx);

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : slot_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_key;
    assign ram_re    = (r_state == S_DISP) && (r_func == FN_READ) && !read_bad;

    // The first modulo of each level runs on (multiplier * key + addend) by the
    // prime; the second on that remainder by the bucket count or bucket size.
    always_comb begin
        div_req          = '0;
        div_req.dividend = DVD_W'(r_prod) + DVD_W'(r_add);
        div_req.divisor  = r_prime;
        case (r_state)
            S_DIVA: begin
                div_req.start = 1'b1;
            end
            S_DIVB: begin
                div_req.start    = 1'b1;
                div_req.short_op = 1'b1;
                div_req.dividend = DVD_W'(r_h);
                div_req.divisor  = r_phase ? DVS_W'(r_size) : DVS_W'(r_bucket_count);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_done         <= 1'b0;
            r_outer_mul    <= OUTER_MUL_RST;
            r_outer_add    <= OUTER_ADD_RST;
            r_prime        <= PRIME_RST;
            r_bucket_count <= BUCKET_COUNT_RST;
            for (int i = 0; i < MAX_BUCKETS; i++) begin
                r_bkt_size[i] <= '0;
                r_bkt_mul[i]  <= '0;
                r_bkt_add[i]  <= '0;
            end
        end else begin
            r_done <= 1'b0;

            if (cfg_wr) begin
                case (cfg_idx)
                    CFG_OUTER_MUL:    r_outer_mul    <= pwdata[15:0];
                    CFG_OUTER_ADD:    r_outer_add    <= pwdata[15:0];
                    CFG_PRIME:        r_prime        <= pwdata[15:0];
                    CFG_BUCKET_COUNT: r_bucket_count <= pwdata[4:0];
                    default:          r_prime        <= r_prime;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        r_func    <= t_func'(i_func);
                        r_key     <= i_key;
                        r_bidx    <= i_bucket_index;
                        r_sidx    <= {1'b0, i_slot_index};
                        r_in_size <= i_bucket_size;
                        r_in_mul  <= i_bucket_mul;
                        r_in_add  <= i_bucket_add;
                        r_bsel    <= BW'(i_bucket_index);
                        r_state   <= S_DISP;
                    end
                end

                S_DISP: begin
                    case (r_func)
                        FN_LOAD: begin
                            r_done   <= 1'b1;
                            r_hbkt   <= r_bidx;
                            r_hslot  <= 5'd0;
                            r_val    <= 16'd0;
                            r_status <= load_bad ? ST_RANGE : ST_OK;
                            if (!load_bad) begin
                                r_bkt_size[r_bsel] <= r_in_size;
                                r_bkt_mul[r_bsel]  <= r_in_mul;
                                r_bkt_add[r_bsel]  <= r_in_add;
                            end
                            r_state <= S_IDLE;
                        end
                        FN_INSERT: begin
                            if (regs_bad) begin
                                r_done   <= 1'b1;
                                r_status <= ST_RANGE;
                                r_hbkt   <= 4'd0;
                                r_hslot  <= 5'd0;
                                r_val    <= r_key;
                                r_state  <= S_IDLE;
                            end else begin
                                r_mul_a <= r_outer_mul;
                                r_add   <= r_outer_add;
                                r_phase <= 1'b0;
                                r_state <= S_MUL;
                            end
                        end
                        FN_READ: begin
                            if (read_bad) begin
                                r_done   <= 1'b1;
                                r_status <= ST_RANGE;
                                r_hbkt   <= r_bidx;
                                r_hslot  <= 5'(r_sidx);
                                r_val    <= 16'd0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_RDWAIT;
                            end
                        end
                        default: begin
                            // Unused command code: range error with empty fields.
                            r_done   <= 1'b1;
                            r_status <= ST_RANGE;
                            r_hbkt   <= 4'd0;
                            r_hslot  <= 5'd0;
                            r_val    <= 16'd0;
                            r_state  <= S_IDLE;
                        end
                    endcase
                end

                S_MUL: begin
                    r_prod  <= r_mul_a * r_key;
                    r_state <= S_DIVA;
                end

                S_DIVA: begin
                    r_state <= S_WAITA;
                end

                S_WAITA: begin
                    if (div_rsp.done) begin
                        r_h     <= div_rsp.rem;
                        r_state <= S_DIVB;
                    end
                end

                S_DIVB: begin
                    r_state <= S_WAITB;
                end

                S_WAITB: begin
                    if (div_rsp.done) begin
                        if (r_phase) begin
                            r_sidx  <= 6'(div_rsp.rem);
                            r_state <= S_WRITE;
                        end else begin
                            r_bsel  <= BW'(div_rsp.rem);
                            r_hbkt  <= 4'(div_rsp.rem);
                            r_state <= S_BKT;
                        end
                    end
                end

                S_BKT: begin
                    if (r_bkt_size[r_bsel] == 6'd0) begin
                        // Bucket without slots: report it and store nothing.
                        r_done   <= 1'b1;
                        r_status <= ST_EMPTY;
                        r_hslot  <= 5'd0;
                        r_val    <= r_key;
                        r_state  <= S_IDLE;
                    end else begin
                        r_mul_a <= r_bkt_mul[r_bsel];
                        r_add   <= r_bkt_add[r_bsel];
                        r_size  <= r_bkt_size[r_bsel];
                        r_phase <= 1'b1;
                        r_state <= S_MUL;
                    end
                end

                S_WRITE: begin
                    r_done   <= 1'b1;
                    r_status <= ST_OK;
                    r_hslot  <= 5'(r_sidx);
                    r_val    <= r_key;
                    r_state  <= S_IDLE;
                end

                S_RDWAIT: begin
                    r_done   <= 1'b1;
                    r_status <= ST_OK;
                    r_hbkt   <= r_bidx;
                    r_hslot  <= 5'(r_sidx);
                    r_val    <= ram_rdata;
                    r_state  <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    tlph_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tlph_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slot_addr),
        .o_rdata (ram_rdata)
    );

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_hit_bucket = r_hbkt;
    assign o_hit_slot   = r_hslot;
    assign o_read_value = r_val;

endmodule

>>> src/tlph_divider.sv
// Restoring remainder unit, one dividend bit per cycle.
module tlph_divider
    import tlph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    // The remainder stays below the divisor, so the trial value fits one extra bit.
    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                if (i_req.short_op) begin
                    r_dvd <= {i_req.dividend[SHORT_STEPS-1:0], (DVD_W-SHORT_STEPS)'(0)};
                    r_cnt <= CNT_W'(SHORT_STEPS);
                end else begin
                    r_dvd <= i_req.dividend;
                    r_cnt <= CNT_W'(LONG_STEPS);
                end
            end else if (r_busy) begin
                r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

>>> src/tlph_slot_ram.sv
// Slot store: one write port, one registered read port.
module tlph_slot_ram
    import tlph_pkg::*;
#(
    parameter int DEPTH = MAX_BUCKETS_DEF * MAX_SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tlph_checker.sv
`include "two_level_perfect_hash_insert_macros.svh"

// Port-level checks on command and result behavior.
module tlph_checker
    import tlph_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [4:0]  o_hit_slot
);

    `TLPH_ASSERT_ALWAYS(a_busy_after_reset, i_clk, !i_rst_n |=> busy, "not busy after reset")
    `TLPH_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, start && !busy |=> busy, "accept ignored")
    `TLPH_ASSERT_RST(a_done_from_work, i_clk, i_rst_n, o_done |-> $past(busy), "result without work")
    `TLPH_ASSERT_RST(a_single_word, i_clk, i_rst_n, o_done |=> !o_done, "result word repeated")
    `TLPH_ASSERT_RST(a_empty_slot, i_clk, i_rst_n, o_done && (o_status == ST_EMPTY) |-> o_hit_slot == 5'd0, "empty bucket gave a slot")

endmodule

bind two_level_perfect_hash_insert tlph_checker u_tlph_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_status   (o_status),
    .o_hit_slot (o_hit_slot)
);
